/* rtl/mtt_pkg.sv */
package mtt_pkg;

   localparam int CP_W   = 21;
   localparam int KIND_W = 4;
   localparam int ERR_W  = 3;
   localparam int MAX_RES = 3;
   localparam int CNT_W  = $clog2(MAX_RES + 1);

   // result kinds
   localparam logic [KIND_W-1:0] K_TEXT_CHAR  = 4'd0;
   localparam logic [KIND_W-1:0] K_TAG_CHAR   = 4'd1;
   localparam logic [KIND_W-1:0] K_ATTR_CHAR  = 4'd2;
   localparam logic [KIND_W-1:0] K_VAL_CHAR   = 4'd3;
   localparam logic [KIND_W-1:0] K_TEXT_END   = 4'd4;
   localparam logic [KIND_W-1:0] K_TAG_END    = 4'd5;
   localparam logic [KIND_W-1:0] K_ATTR_END   = 4'd6;
   localparam logic [KIND_W-1:0] K_VAL_END    = 4'd7;
   localparam logic [KIND_W-1:0] K_OPEN       = 4'd8;
   localparam logic [KIND_W-1:0] K_CLOSE      = 4'd9;
   localparam logic [KIND_W-1:0] K_SELFCLOSE  = 4'd10;
   localparam logic [KIND_W-1:0] K_ERROR      = 4'd11;
   localparam logic [KIND_W-1:0] K_STREAM_END = 4'd12;

   // error codes
   localparam logic [ERR_W-1:0] E_NONE        = 3'd0;
   localparam logic [ERR_W-1:0] E_BAD_START   = 3'd1;
   localparam logic [ERR_W-1:0] E_EMPTY_TAG   = 3'd2;
   localparam logic [ERR_W-1:0] E_EMPTY_ATTR  = 3'd3;
   localparam logic [ERR_W-1:0] E_BAD_ATTR    = 3'd4;
   localparam logic [ERR_W-1:0] E_NO_EQUAL    = 3'd5;
   localparam logic [ERR_W-1:0] E_BAD_SELF    = 3'd6;
   localparam logic [ERR_W-1:0] E_AFTER_VALUE = 3'd7;

   typedef enum logic [7:0] {
      M_TEXT       = 8'b0000_0001,
      M_SWITCH     = 8'b0000_0010,
      M_TAGNAME    = 8'b0000_0100,
      M_ATTRNAME   = 8'b0000_1000,
      M_EXPECT_EQ  = 8'b0001_0000,
      M_VALUE      = 8'b0010_0000,
      M_END_OR_NEW = 8'b0100_0000,
      M_SELFCLOSE  = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic     skip;
      logic     nonempty;
   } pstate_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CP_W-1:0]   char_out;
      logic [ERR_W-1:0]  error_code;
   } res_type;

endpackage

/* rtl/mtt_if.sv */
interface mtt_req_if;
   logic                      valid;
   logic                      ready;
   logic [mtt_pkg::CP_W-1:0]  code_point;
   logic                      end_of_stream;

   modport source (output valid, output code_point, output end_of_stream, input ready);
   modport sink   (input valid, input code_point, input end_of_stream, output ready);
endinterface

interface mtt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mtt_pkg::KIND_W-1:0] kind;
   logic [mtt_pkg::CP_W-1:0]   char_out;
   logic [mtt_pkg::ERR_W-1:0]  error_code;
   logic                       last;

   modport source (output valid, output kind, output char_out, output error_code,
                   output last, input ready);
   modport sink   (input valid, input kind, input char_out, input error_code,
                   input last, output ready);
endinterface

/* rtl/mtt_decode.sv */
module mtt_decode (
   input  mtt_pkg::pstate_type           state_ff,
   input  logic                          err_ff,
   input  logic [mtt_pkg::ERR_W-1:0]     code_ff,
   input  logic [mtt_pkg::CP_W-1:0]      cp,
   input  logic                          eos,
   output mtt_pkg::pstate_type           state_in,
   output logic                          err_in,
   output logic [mtt_pkg::ERR_W-1:0]     code_in,
   output mtt_pkg::res_type              res_in [mtt_pkg::MAX_RES],
   output logic [mtt_pkg::CNT_W-1:0]     cnt_in
);
   import mtt_pkg::*;

   localparam int MaxPasses = 3;

   localparam logic [CP_W-1:0] CH_LT    = 21'h3C;
   localparam logic [CP_W-1:0] CH_GT    = 21'h3E;
   localparam logic [CP_W-1:0] CH_SLASH = 21'h2F;
   localparam logic [CP_W-1:0] CH_EQ    = 21'h3D;
   localparam logic [CP_W-1:0] CH_BANG  = 21'h21;
   localparam logic [CP_W-1:0] CH_SP    = 21'h20;
   localparam logic [CP_W-1:0] CH_TAB   = 21'h09;
   localparam logic [CP_W-1:0] CH_CR    = 21'h0D;
   localparam logic [CP_W-1:0] CH_0     = 21'h30;
   localparam logic [CP_W-1:0] CH_9     = 21'h39;
   localparam logic [CP_W-1:0] CH_UA    = 21'h41;
   localparam logic [CP_W-1:0] CH_UZ    = 21'h5A;
   localparam logic [CP_W-1:0] CH_LA    = 21'h61;
   localparam logic [CP_W-1:0] CH_LZ    = 21'h7A;

   function automatic res_type mk(logic [KIND_W-1:0] k, logic [CP_W-1:0] ch,
                                  logic [ERR_W-1:0] e);
      res_type r;
      r.kind       = k;
      r.char_out   = ch;
      r.error_code = e;
      return r;
   endfunction

   logic is_ws, is_alnum, is_name;
   logic is_lt, is_gt, is_slash, is_eq;
   logic done;
   pstate_type st;
   res_type res [MAX_RES];
   logic [CNT_W-1:0] cnt;

   assign is_ws    = (cp == CH_SP) || (cp >= CH_TAB && cp <= CH_CR);
   assign is_alnum = (cp >= CH_0 && cp <= CH_9) || (cp >= CH_UA && cp <= CH_UZ) ||
                     (cp >= CH_LA && cp <= CH_LZ);
   assign is_name  = is_alnum || (cp == CH_BANG);
   assign is_lt    = (cp == CH_LT);
   assign is_gt    = (cp == CH_GT);
   assign is_slash = (cp == CH_SLASH);
   assign is_eq    = (cp == CH_EQ);

   always_comb begin
      st      = state_ff;
      err_in  = err_ff;
      code_in = code_ff;
      cnt     = '0;
      done    = 1'b0;
      for (int i = 0; i < MAX_RES; i++) begin
         res[i] = '0;
      end

      if (err_ff) begin
         res[0] = mk(K_ERROR, '0, code_ff);
         cnt    = CNT_W'(1);
      end else if (eos) begin
         res[0] = mk(K_STREAM_END, '0, E_NONE);
         cnt    = CNT_W'(1);
      end else begin
         // one pass per state the character walks through; never more than three
         for (int p = 0; p < MaxPasses; p++) begin
            if (!done) begin
               if (st.skip && is_ws) begin
                  done = 1'b1;
               end else begin
                  st.skip = 1'b0;
                  unique case (st.mode)
                     M_SWITCH: begin
                        if (is_slash) begin
                           res[cnt] = mk(K_CLOSE, '0, E_NONE); cnt = cnt + CNT_W'(1);
                           st.mode = M_TAGNAME; st.skip = 1'b1; st.nonempty = 1'b0;
                           done = 1'b1;
                        end else if (is_name) begin
                           res[cnt] = mk(K_OPEN, '0, E_NONE); cnt = cnt + CNT_W'(1);
                           st.mode = M_TAGNAME; st.nonempty = 1'b0;
                        end else begin
                           err_in = 1'b1; code_in = E_BAD_START;
                           res[cnt] = mk(K_ERROR, '0, E_BAD_START); cnt = cnt + CNT_W'(1);
                           done = 1'b1;
                        end
                     end
                     M_TAGNAME: begin
                        if (is_name) begin
                           res[cnt] = mk(K_TAG_CHAR, cp, E_NONE); cnt = cnt + CNT_W'(1);
                           st.nonempty = 1'b1;
                           done = 1'b1;
                        end else if (!st.nonempty) begin
                           err_in = 1'b1; code_in = E_EMPTY_TAG;
                           res[cnt] = mk(K_ERROR, '0, E_EMPTY_TAG); cnt = cnt + CNT_W'(1);
                           done = 1'b1;
                        end else begin
                           res[cnt] = mk(K_TAG_END, '0, E_NONE); cnt = cnt + CNT_W'(1);
                           st.mode = M_ATTRNAME; st.skip = 1'b1; st.nonempty = 1'b0;
                        end
                     end
                     M_ATTRNAME: begin
                        done = 1'b1;
                        if (is_alnum) begin
                           res[cnt] = mk(K_ATTR_CHAR, cp, E_NONE); cnt = cnt + CNT_W'(1);
                           st.nonempty = 1'b1;
                        end else if (is_eq) begin
                           if (!st.nonempty) begin
                              err_in = 1'b1; code_in = E_EMPTY_ATTR;
                              res[cnt] = mk(K_ERROR, '0, E_EMPTY_ATTR);
                              cnt = cnt + CNT_W'(1);
                           end else begin
                              res[cnt] = mk(K_ATTR_END, '0, E_NONE); cnt = cnt + CNT_W'(1);
                              st.mode = M_VALUE; st.skip = 1'b1; st.nonempty = 1'b0;
                           end
                        end else if (!is_gt && !is_slash && !is_ws) begin
                           err_in = 1'b1; code_in = E_BAD_ATTR;
                           res[cnt] = mk(K_ERROR, '0, E_BAD_ATTR); cnt = cnt + CNT_W'(1);
                        end else begin
                           if (st.nonempty) begin
                              res[cnt] = mk(K_ATTR_END, '0, E_NONE); cnt = cnt + CNT_W'(1);
                           end
                           st.nonempty = 1'b0;
                           if (is_gt) begin
                              st.mode = M_TEXT; st.skip = 1'b1;
                           end else if (is_slash) begin
                              st.mode = M_SELFCLOSE;
                           end else begin
                              st.mode = M_EXPECT_EQ; st.skip = 1'b1;
                           end
                        end
                     end
                     M_EXPECT_EQ: begin
                        done = 1'b1;
                        if (is_eq) begin
                           st.mode = M_VALUE; st.skip = 1'b1; st.nonempty = 1'b0;
                        end else begin
                           err_in = 1'b1; code_in = E_NO_EQUAL;
                           res[cnt] = mk(K_ERROR, '0, E_NO_EQUAL); cnt = cnt + CNT_W'(1);
                        end
                     end
                     M_VALUE: begin
                        if (is_alnum) begin
                           res[cnt] = mk(K_VAL_CHAR, cp, E_NONE); cnt = cnt + CNT_W'(1);
                           st.nonempty = 1'b1;
                           done = 1'b1;
                        end else begin
                           res[cnt] = mk(K_VAL_END, '0, E_NONE); cnt = cnt + CNT_W'(1);
                           st.mode = M_END_OR_NEW; st.skip = 1'b1; st.nonempty = 1'b0;
                        end
                     end
                     M_END_OR_NEW: begin
                        if (is_alnum) begin
                           st.mode = M_ATTRNAME; st.nonempty = 1'b0;
                        end else if (is_gt) begin
                           st.mode = M_TEXT; st.skip = 1'b1; st.nonempty = 1'b0;
                           done = 1'b1;
                        end else if (is_slash) begin
                           st.mode = M_SELFCLOSE;
                           done = 1'b1;
                        end else begin
                           err_in = 1'b1; code_in = E_AFTER_VALUE;
                           res[cnt] = mk(K_ERROR, '0, E_AFTER_VALUE); cnt = cnt + CNT_W'(1);
                           done = 1'b1;
                        end
                     end
                     M_SELFCLOSE: begin
                        done = 1'b1;
                        if (is_gt) begin
                           res[cnt] = mk(K_SELFCLOSE, '0, E_NONE); cnt = cnt + CNT_W'(1);
                           st.mode = M_TEXT; st.skip = 1'b1; st.nonempty = 1'b0;
                        end else begin
                           err_in = 1'b1; code_in = E_BAD_SELF;
                           res[cnt] = mk(K_ERROR, '0, E_BAD_SELF); cnt = cnt + CNT_W'(1);
                        end
                     end
                     default: begin
                        // text mode
                        done = 1'b1;
                        if (is_lt) begin
                           if (st.nonempty) begin
                              res[cnt] = mk(K_TEXT_END, '0, E_NONE); cnt = cnt + CNT_W'(1);
                           end
                           st.mode = M_SWITCH; st.skip = 1'b1; st.nonempty = 1'b0;
                        end else begin
                           res[cnt] = mk(K_TEXT_CHAR, cp, E_NONE); cnt = cnt + CNT_W'(1);
                           st.nonempty = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
      end

      state_in = st;
      cnt_in   = cnt;
      for (int i = 0; i < MAX_RES; i++) begin
         res_in[i] = res[i];
      end
   end

endmodule

/* rtl/markup_tag_tokenizer.sv */
// Channel  Dir  Payload                                   Transfer
// req      in   code_point[20:0], end_of_stream           valid && ready
// rsp      out  kind[3:0], char_out[20:0], error_code[2:0],
//               last                                      valid && ready
//
// One item is taken per cycle, unless the result buffer backs up, into an input register, decoded
// combinationally into up to three results, and loaded into a three-entry result buffer.
// The buffer sends one result per cycle while rsp.ready is high.
// A new item is taken while the buffer drains its final result.
// Reset (synchronous) returns the parser to text mode and clears the sticky error.
module markup_tag_tokenizer (
   input logic     clock,
   input logic     reset,
   mtt_req_if.sink   req,
   mtt_rsp_if.source rsp
);
   import mtt_pkg::*;

   logic             in_valid_ff;
   logic [CP_W-1:0]  cp_ff;
   logic             eos_ff;

   pstate_type       state_ff, state_in;
   logic             err_ff, err_in;
   logic [ERR_W-1:0] code_ff, code_in;

   res_type          res_ff [MAX_RES];
   res_type          res_in [MAX_RES];
   logic [CNT_W-1:0] cnt_in;
   logic [CNT_W-1:0] rem_ff;
   logic [CNT_W-1:0] pos_ff;

   logic proc;
   logic out_xfer;
   logic in_xfer;

   mtt_decode u_decode (
      .state_ff (state_ff),
      .err_ff   (err_ff),
      .code_ff  (code_ff),
      .cp       (cp_ff),
      .eos      (eos_ff),
      .state_in (state_in),
      .err_in   (err_in),
      .code_in  (code_in),
      .res_in   (res_in),
      .cnt_in   (cnt_in)
   );

   // decode when the buffer is empty or hands off its final result this cycle
   assign proc     = in_valid_ff &&
                     ((rem_ff == '0) || ((rem_ff == CNT_W'(1)) && rsp.ready));
   assign req.ready = !in_valid_ff || proc;
   assign in_xfer  = req.valid && req.ready;
   assign out_xfer = rsp.valid && rsp.ready;

   assign rsp.valid      = (rem_ff != '0);
   assign rsp.kind       = res_ff[pos_ff].kind;
   assign rsp.char_out   = res_ff[pos_ff].char_out;
   assign rsp.error_code = res_ff[pos_ff].error_code;
   assign rsp.last       = (rem_ff == CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rem_ff            <= '0;
         pos_ff            <= '0;
         state_ff.mode     <= M_TEXT;
         state_ff.skip     <= 1'b1;
         state_ff.nonempty <= 1'b0;
         err_ff            <= 1'b0;
         code_ff           <= E_NONE;
      end else begin
         if (in_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (proc) begin
            in_valid_ff <= 1'b0;
         end
         if (proc) begin
            rem_ff   <= cnt_in;
            pos_ff   <= '0;
            state_ff <= state_in;
            err_ff   <= err_in;
            code_ff  <= code_in;
         end else if (out_xfer) begin
            rem_ff <= rem_ff - CNT_W'(1);
            pos_ff <= pos_ff + CNT_W'(1);
         end
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (in_xfer) begin
         cp_ff  <= req.code_point;
         eos_ff <= req.end_of_stream;
      end
      if (proc) begin
         for (int i = 0; i < MAX_RES; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("sticky error cleared without reset");

   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.kind == K_ERROR)) |-> err_ff)
      else $error("error result sent while no error is held");

   a_stuck_reply: assert property (@(posedge clock) disable iff (reset)
      (proc && err_ff) |=> (rsp.valid && rsp.last && (rsp.kind == K_ERROR)))
      else $error("item after an error did not give a single error result");

   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rem_ff} + {1'b0, pos_ff}) <= (CNT_W + 1)'(MAX_RES))
      else $error("result buffer read beyond its entries");

endmodule

/* bench/testbench.sv */
import mtt_pkg::*;

localparam logic [CP_W-1:0] CH_TAB   = 21'h09;
localparam logic [CP_W-1:0] CH_LF    = 21'h0A;
localparam logic [CP_W-1:0] CH_VT    = 21'h0B;
localparam logic [CP_W-1:0] CH_FF    = 21'h0C;
localparam logic [CP_W-1:0] CH_CR    = 21'h0D;
localparam logic [CP_W-1:0] CH_SP    = 21'h20;
localparam logic [CP_W-1:0] CH_BANG  = 21'h21;
localparam logic [CP_W-1:0] CH_HASH  = 21'h23;
localparam logic [CP_W-1:0] CH_SLASH = 21'h2F;
localparam logic [CP_W-1:0] CH_LT    = 21'h3C;
localparam logic [CP_W-1:0] CH_EQ    = 21'h3D;
localparam logic [CP_W-1:0] CH_GT    = 21'h3E;

class token_board;
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [CP_W-1:0]   ch;
      logic [ERR_W-1:0]  code;
      logic              last;
   } token_rec_type;

   mode_type          mode;
   bit                skip;
   bit                nonempty;
   bit                stuck;
   logic [ERR_W-1:0]  stuck_code;
   token_rec_type     step_tokens[$];
   token_rec_type     pending_tokens[$];
   int                fail_count;
   int                checked_count;

   function new();
      mode = M_TEXT;
      skip = 1'b1;
      nonempty = 1'b0;
      stuck = 1'b0;
      stuck_code = E_NONE;
      fail_count = 0;
      checked_count = 0;
   endfunction

   function bit is_blank(logic [CP_W-1:0] c);
      return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function bit is_alnum(logic [CP_W-1:0] c);
      return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h41 && c <= 21'h5A) ||
             (c >= 21'h61 && c <= 21'h7A);
   endfunction

   function bit is_name(logic [CP_W-1:0] c);
      return is_alnum(c) || c == CH_BANG;
   endfunction

   function void emit(logic [KIND_W-1:0] kind, logic [CP_W-1:0] ch, logic [ERR_W-1:0] code);
      token_rec_type r;
      if (step_tokens.size() >= MAX_RES) return;
      r.kind = kind;
      r.ch = ch;
      r.code = code;
      r.last = 1'b0;
      step_tokens = {step_tokens, r};
   endfunction

   function void fail(logic [ERR_W-1:0] code);
      stuck = 1'b1;
      stuck_code = code;
      emit(K_ERROR, '0, code);
   endfunction

   function void enter(mode_type m, bit sk);
      mode = m;
      skip = sk;
      nonempty = 1'b0;
   endfunction

   function void parse_char(logic [CP_W-1:0] c);
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         if (skip) begin
            if (is_blank(c)) return;
            skip = 1'b0;
         end
         case (mode)
            M_SWITCH: begin
               if (c == CH_SLASH) begin
                  emit(K_CLOSE, '0, E_NONE);
                  enter(M_TAGNAME, 1'b1);
               end else if (is_name(c)) begin
                  emit(K_OPEN, '0, E_NONE);
                  enter(M_TAGNAME, 1'b0);
                  again = 1'b1;
               end else begin
                  fail(E_BAD_START);
               end
            end
            M_TAGNAME: begin
               if (is_name(c)) begin
                  emit(K_TAG_CHAR, c, E_NONE);
                  nonempty = 1'b1;
               end else if (!nonempty) begin
                  fail(E_EMPTY_TAG);
               end else begin
                  emit(K_TAG_END, '0, E_NONE);
                  enter(M_ATTRNAME, 1'b1);
                  again = 1'b1;
               end
            end
            M_ATTRNAME: begin
               if (is_alnum(c)) begin
                  emit(K_ATTR_CHAR, c, E_NONE);
                  nonempty = 1'b1;
               end else if (c == CH_EQ) begin
                  if (!nonempty) begin
                     fail(E_EMPTY_ATTR);
                  end else begin
                     emit(K_ATTR_END, '0, E_NONE);
                     enter(M_VALUE, 1'b1);
                  end
               end else if (c != CH_GT && c != CH_SLASH && !is_blank(c)) begin
                  fail(E_BAD_ATTR);
               end else begin
                  // name ended without '=': close it only if it holds characters
                  if (nonempty) emit(K_ATTR_END, '0, E_NONE);
                  nonempty = 1'b0;
                  if (c == CH_GT) begin
                     enter(M_TEXT, 1'b1);
                  end else if (c == CH_SLASH) begin
                     mode = M_SELFCLOSE;
                  end else begin
                     mode = M_EXPECT_EQ;
                     skip = 1'b1;
                  end
               end
            end
            M_EXPECT_EQ: begin
               if (c == CH_EQ) enter(M_VALUE, 1'b1);
               else fail(E_NO_EQUAL);
            end
            M_VALUE: begin
               if (is_alnum(c)) begin
                  emit(K_VAL_CHAR, c, E_NONE);
                  nonempty = 1'b1;
               end else begin
                  emit(K_VAL_END, '0, E_NONE);
                  enter(M_END_OR_NEW, 1'b1);
                  again = 1'b1;
               end
            end
            M_END_OR_NEW: begin
               if (is_alnum(c)) begin
                  enter(M_ATTRNAME, 1'b0);
                  again = 1'b1;
               end else if (c == CH_GT) begin
                  enter(M_TEXT, 1'b1);
               end else if (c == CH_SLASH) begin
                  mode = M_SELFCLOSE;
               end else begin
                  fail(E_AFTER_VALUE);
               end
            end
            M_SELFCLOSE: begin
               if (c == CH_GT) begin
                  emit(K_SELFCLOSE, '0, E_NONE);
                  enter(M_TEXT, 1'b1);
               end else begin
                  fail(E_BAD_SELF);
               end
            end
            default: begin
               if (c == CH_LT) begin
                  if (nonempty) emit(K_TEXT_END, '0, E_NONE);
                  enter(M_SWITCH, 1'b1);
               end else begin
                  emit(K_TEXT_CHAR, c, E_NONE);
                  nonempty = 1'b1;
               end
            end
         endcase
      end
   endfunction

   // Work out the tokens that one accepted character causes and queue them.
   function void note_char(logic [CP_W-1:0] cp, logic eos);
      step_tokens.delete();
      if (stuck) emit(K_ERROR, '0, stuck_code);
      else if (eos) emit(K_STREAM_END, '0, E_NONE);
      else parse_char(cp);
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      pending_tokens = {pending_tokens, step_tokens};
   endfunction

   task report(string msg);
      fail_count++;
      if (fail_count <= 50) $display("MISMATCH: %s", msg);
   endtask

   task check_token(logic [KIND_W-1:0] kind, logic [CP_W-1:0] ch, logic [ERR_W-1:0] code,
                    logic last);
      token_rec_type want;
      if (pending_tokens.size() == 0) begin
         report($sformatf("unexpected token kind %0d char %h code %0d last %b",
                          kind, ch, code, last));
         return;
      end
      want = pending_tokens.pop_front();
      checked_count++;
      if (kind !== want.kind || ch !== want.ch || code !== want.code || last !== want.last)
         report($sformatf("token %0d: got kind %0d char %h code %0d last %b, want %0d %h %0d %b",
                          checked_count, kind, ch, code, last,
                          want.kind, want.ch, want.code, want.last));
   endtask
endclass

module testbench;
   localparam int LIMIT_CYCLES = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mtt_req_if req_ch ();
   mtt_rsp_if rsp_ch ();

   markup_tag_tokenizer u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   token_board board;
   int send_idle_pct = 13;
   int recv_idle_pct = 51;
   bit hold_rsp = 1'b0;
   int cycle_count = 0;
   int items_sent = 0;
   int eos_sent = 0;
   int tags_sent = 0;
   logic [ERR_W-1:0] err_pick = E_NONE;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input logic [CP_W-1:0] cp, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.code_point <= cp;
      req_ch.end_of_stream <= eos;
      do @(posedge clock); while (!req_ch.ready);
      board.note_char(cp, eos);
      items_sent++;
      if (eos) eos_sent++;
      @(negedge clock);
   endtask

   // a character, now and then followed by a stream end with junk in the code point
   task automatic send_char(input logic [CP_W-1:0] c);
      send_item(c, 1'b0);
      if ($urandom_range(39) == 0) send_item(CP_W'($urandom_range(21'h1FFFFF)), 1'b1);
   endtask

   function automatic logic [CP_W-1:0] pick_blank();
      if ($urandom_range(5) == 5) return CH_SP;
      return CH_TAB + CP_W'($urandom_range(4));
   endfunction

   function automatic logic [CP_W-1:0] pick_alnum();
      case ($urandom_range(2))
         0: return 21'h30 + CP_W'($urandom_range(9));
         1: return 21'h41 + CP_W'($urandom_range(25));
         default: return 21'h61 + CP_W'($urandom_range(25));
      endcase
   endfunction

   function automatic logic [CP_W-1:0] pick_text_char();
      logic [CP_W-1:0] c;
      case ($urandom_range(3))
         0: c = CP_W'($urandom_range(8'h7E, 8'h20));
         1: c = pick_blank();
         2: c = CP_W'($urandom_range(21'h1FFFFF));
         default: c = pick_alnum();
      endcase
      if (c == CH_LT) c = CH_GT;
      return c;
   endfunction

   task automatic send_blanks(input int lo, input int hi);
      repeat ($urandom_range(hi, lo)) send_char(pick_blank());
   endtask

   task automatic send_text();
      repeat ($urandom_range(6)) send_char(pick_text_char());
   endtask

   task automatic send_tag();
      int n_attr;
      bit bare_last;
      n_attr = $urandom_range(3);
      bare_last = 1'b0;
      tags_sent++;
      send_char(CH_LT);
      send_blanks(0, 2);
      if ($urandom_range(3) == 0) begin
         send_char(CH_SLASH);
         send_blanks(0, 2);
      end
      repeat ($urandom_range(4, 1))
         send_char(($urandom_range(7) == 0) ? CH_BANG : pick_alnum());
      for (int i = 0; i < n_attr; i++) begin
         send_blanks(1, 3);
         repeat ($urandom_range(4, 1)) send_char(pick_alnum());
         // only the final attribute may go without a value or with an empty one
         if (i == n_attr - 1 && $urandom_range(2) == 0) begin
            bare_last = 1'b1;
         end else begin
            send_blanks(0, 2);
            send_char(CH_EQ);
            send_blanks(0, 2);
            repeat ($urandom_range(4, (i == n_attr - 1) ? 0 : 1)) send_char(pick_alnum());
         end
      end
      if (!bare_last) send_blanks(0, 2);
      if ($urandom_range(2) == 0) send_char(CH_SLASH);
      send_char(CH_GT);
   endtask

   task automatic send_markup(input int target);
      while (items_sent < target) begin
         send_text();
         send_tag();
      end
   endtask

   task automatic send_broken_tag();
      logic [CP_W-1:0] seq[$];
      err_pick = ERR_W'($urandom_range(E_AFTER_VALUE, E_BAD_START));
      case (err_pick)
         E_BAD_START:  seq = '{CH_LT, CH_HASH};
         E_EMPTY_TAG:  seq = '{CH_LT, CH_SLASH, CH_GT};
         E_EMPTY_ATTR: seq = '{CH_LT, 21'h61, CH_SP, CH_EQ};
         E_BAD_ATTR:   seq = '{CH_LT, 21'h61, CH_SP, 21'h62, CH_HASH};
         E_NO_EQUAL:   seq = '{CH_LT, 21'h61, CH_SP, 21'h62, CH_SP, 21'h63};
         E_BAD_SELF:   seq = '{CH_LT, 21'h61, CH_SLASH, 21'h78};
         default:      seq = '{CH_LT, 21'h61, CH_SP, 21'h62, CH_EQ, 21'h31, CH_HASH};
      endcase
      foreach (seq[i]) send_item(seq[i], 1'b0);
      // the error must stick for everything that follows
      repeat (4) send_item(pick_text_char(), 1'b0);
      send_item(CP_W'($urandom_range(21'h1FFFFF)), 1'b1);
      send_item(CH_LT, 1'b0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_token(rsp_ch.kind, rsp_ch.char_out, rsp_ch.error_code, rsp_ch.last);
   end

   initial begin
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // stall the output long enough for the result buffer to fill and back up the input
   initial begin : output_stall
      wait (items_sent >= 60);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (150) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      board = new();
      req_ch.valid = 1'b0;
      req_ch.code_point = '0;
      req_ch.end_of_stream = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: leading blank, extreme code points, trailing text, close and self-closing tags
      send_item(CH_SP, 1'b0);
      send_item(21'h1FFFFF, 1'b0);
      send_item(21'h0, 1'b0);
      send_item(CH_TAB, 1'b0);
      send_item(21'h1FFFFF, 1'b1);
      send_item(CH_LT, 1'b0);
      send_item(CH_CR, 1'b0);
      send_item(CH_BANG, 1'b0);
      send_item(21'h5A, 1'b0);
      send_item(CH_VT, 1'b0);
      send_item(21'h71, 1'b0);
      send_item(CH_FF, 1'b0);
      send_item(CH_EQ, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(21'h39, 1'b0);
      send_item(CH_SLASH, 1'b0);
      send_item(CH_GT, 1'b0);
      send_item(CH_LT, 1'b0);
      send_item(CH_SLASH, 1'b0);
      send_item(21'h62, 1'b0);
      send_item(CH_GT, 1'b0);
      send_item(CH_LT, 1'b0);
      send_item(21'h61, 1'b0);
      send_item(CH_SLASH, 1'b0);
      send_item(CH_GT, 1'b0);

      send_markup(135);
      send_idle_pct = 51;
      recv_idle_pct = 13;
      send_markup(245);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_markup(355);
      send_idle_pct = 13;
      recv_idle_pct = 51;
      send_broken_tag();
      req_ch.valid <= 1'b0;

      while (board.pending_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d characters and stream ends (%0d ends, %0d tags), %0d tokens checked,",
               items_sent, eos_sent, tags_sent, board.checked_count);
      $display("a long output stall, and a sticky error of code %0d at the close.", err_pick);
      if (board.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/mtt_pkg.sv
rtl/mtt_if.sv
rtl/mtt_decode.sv
rtl/markup_tag_tokenizer.sv
bench/testbench.sv
